/* src/bdac_pkg.sv */
// Package for the binary to decimal ASCII converter.
// Holds the field widths, the ASCII and BCD constants and the digit-count helper.
// Used by every module in src; depends on nothing.
package bdac_pkg;

	// Widths of the fields on the block's ports.
	localparam int NUMBER_W = 64;
	localparam int DIGIT_CHAR_W = 6;
	localparam int DIGIT_COUNT_W = 5;

	// Default width of the converted value.
	localparam int DEFAULT_VALUE_WIDTH = 64;

	// One BCD digit and the double-dabble correction constants.
	localparam int BCD_W = 4;
	localparam logic [BCD_W-1:0] DABBLE_LIMIT = 4'd5;
	localparam logic [BCD_W-1:0] DABBLE_ADD = 4'd3;

	// ASCII code of the character '0', kept to the width of the digit field.
	localparam logic [DIGIT_CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// Number of decimal digits in the largest value of the given bit width.
	// This is floor(width * log10(2)) + 1, exact for widths up to 64.
	function automatic int max_digits(input int width);
		return (width * 30103) / 100000 + 1;
	endfunction

endpackage

/* src/binary_to_decimal_ascii_top.sv */
// Top level of the binary to decimal ASCII converter.
// Instantiates bdac_front, bdac_fifo and bdac_back; depends on bdac_pkg.
//
// Usage:
// An item is accepted at a rising edge where start is high and busy is low;
// number is sampled there and only its low VALUE_WIDTH bits are converted.
// Results come out one decimal digit per cycle, most significant first, with
// no leading zeros (zero gives a single '0'). Each result is shown for one
// cycle with valid high and carries digit_char (ASCII), digit_count (total
// digits of the value) and last_digit on the least significant digit.
// The digits of one value always come out on consecutive cycles.
// The rate is set by the front end's shift-and-add-3 loop, which handles one
// input bit per cycle, waits while the queue is full and takes no new value
// until it has queued the last one. The emitter registers each digit it sends.
// A two-entry queue lets the next conversion run while digits still go out.
// Reset clears all control state; the block then idles with busy low.
// The receiver cannot stall: every result is taken in the cycle it is shown.
module binary_to_decimal_ascii_top
	import bdac_pkg::*;
#(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [NUMBER_W-1:0]       number,
	output logic                      valid,
	output logic [DIGIT_CHAR_W-1:0]   digit_char,
	output logic [DIGIT_COUNT_W-1:0]  digit_count,
	output logic                      last_digit
);

	localparam int NDIG = max_digits(VALUE_WIDTH);
	localparam int CW = $clog2(NDIG + 1);
	localparam int ENTRY_W = CW + BCD_W * NDIG;

	logic                    push;
	logic                    full;
	logic                    pop;
	logic                    empty;
	logic [BCD_W*NDIG-1:0]   front_digits;
	logic [CW-1:0]           front_count;
	logic [ENTRY_W-1:0]      rd_entry;

	// Conversion front end.
	bdac_front #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NDIG        (NDIG),
		.CW          (CW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (number[VALUE_WIDTH-1:0]),
		.busy   (busy),
		.push   (push),
		.full   (full),
		.digits (front_digits),
		.count  (front_count)
	);

	// Queue of converted values.
	bdac_fifo #(
		.DATA_W (ENTRY_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({front_count, front_digits}),
		.full   (full),
		.pop    (pop),
		.rdata  (rd_entry),
		.empty  (empty)
	);

	// Digit emitter.
	bdac_back #(
		.NDIG (NDIG),
		.CW   (CW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.digits      (rd_entry[BCD_W*NDIG-1:0]),
		.count       (rd_entry[ENTRY_W-1:BCD_W*NDIG]),
		.pop         (pop),
		.valid       (valid),
		.digit_char  (digit_char),
		.digit_count (digit_count),
		.last_digit  (last_digit)
	);

`ifndef SYNTHESIS
	// The digits of one value leave on consecutive cycles.
	a_digits_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_digit |=> valid)
		else $error("digit run broken before the last digit");

	// The digit count holds across one value's run.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_digit |=> digit_count == $past(digit_count))
		else $error("digit count changed inside a run");

	// Every character sent is a decimal digit.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + 6'd9))
		else $error("non-digit character sent");

	// An accepted transaction makes the block busy on the next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted transaction");
`endif

endmodule

/* src/bdac_front.sv */
// Front end of the converter: accepts a value and turns it into BCD digits.
// Runs one shift-and-add-3 step per input bit and tracks the digit count.
// Depends on bdac_pkg.
module bdac_front
	import bdac_pkg::*;
#(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
	parameter int NDIG = max_digits(DEFAULT_VALUE_WIDTH),
	parameter int CW = $clog2(max_digits(DEFAULT_VALUE_WIDTH) + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [VALUE_WIDTH-1:0]  value,
	output logic                    busy,
	output logic                    push,
	input  logic                    full,
	output logic [BCD_W*NDIG-1:0]   digits,
	output logic [CW-1:0]           count
);

	localparam int IW = $clog2(NDIG);
	localparam int BW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]               state_q;
	logic [BW-1:0]            bit_q;
	logic [VALUE_WIDTH-1:0]   sh_q;
	logic [BCD_W*NDIG-1:0]    bcd_q;
	logic [CW-1:0]            cnt_q;

	logic [BCD_W*NDIG-1:0]    adj_vec;
	logic [BCD_W*NDIG-1:0]    bcd_next;
	logic [BCD_W-1:0]         top_digit;
	logic                     grow;

	// Add 3 to every digit of 5 or more, then shift in the next value bit.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*BCD_W +: BCD_W] >= DABBLE_LIMIT) begin
				adj_vec[i*BCD_W +: BCD_W] = bcd_q[i*BCD_W +: BCD_W] + DABBLE_ADD;
			end else begin
				adj_vec[i*BCD_W +: BCD_W] = bcd_q[i*BCD_W +: BCD_W];
			end
		end
		bcd_next = {adj_vec[BCD_W*NDIG-2:0], sh_q[VALUE_WIDTH-1]};
	end

	// The value at most doubles per step, so the count grows by at most one:
	// only the digit just above the current top needs a look.
	always_comb begin
		if (cnt_q < CW'(NDIG)) begin
			top_digit = bcd_next[cnt_q[IW-1:0]*BCD_W +: BCD_W];
			grow = (top_digit != '0);
		end else begin
			top_digit = '0;
			grow = 1'b0;
		end
	end

	// Sequencer: idle, one step per bit, then hand the digits to the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
						bit_q <= BW'(VALUE_WIDTH - 1);
					end
				end
				ST_CONV: begin
					if (bit_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (!full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Conversion datapath.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			sh_q <= value;
			bcd_q <= '0;
			cnt_q <= CW'(1);
		end else if (state_q == ST_CONV) begin
			sh_q <= {sh_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= bcd_next;
			if (grow) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign push = (state_q == ST_DONE);
	assign digits = bcd_q;
	assign count = cnt_q;

endmodule

/* src/bdac_fifo.sv */
// Two-entry queue between the converter front end and the digit emitter.
// Each entry holds one converted value: its digit count and BCD digits.
// Depends on bdac_pkg for the constants of its default entry width.
module bdac_fifo
	import bdac_pkg::*;
#(
	parameter int DATA_W = BCD_W * max_digits(DEFAULT_VALUE_WIDTH) + DIGIT_COUNT_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              empty
);

	localparam int DEPTH = 2;
	localparam int PW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [FW-1:0]     fill_q;
	logic              do_push;
	logic              do_pop;

	assign full = (fill_q == FW'(DEPTH));
	assign empty = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// Pointers wrap on their own since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* src/bdac_back.sv */
// Back end of the converter: sends the digits of one queued value as ASCII.
// One digit per cycle, most significant first, with count and last flag.
// Depends on bdac_pkg.
module bdac_back
	import bdac_pkg::*;
#(
	parameter int NDIG = max_digits(DEFAULT_VALUE_WIDTH),
	parameter int CW = $clog2(max_digits(DEFAULT_VALUE_WIDTH) + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      empty,
	input  logic [BCD_W*NDIG-1:0]     digits,
	input  logic [CW-1:0]             count,
	output logic                      pop,
	output logic                      valid,
	output logic [DIGIT_CHAR_W-1:0]   digit_char,
	output logic [DIGIT_COUNT_W-1:0]  digit_count,
	output logic                      last_digit
);

	localparam int IW = $clog2(NDIG);

	logic                     active_q;
	logic [BCD_W*NDIG-1:0]    digits_q;
	logic [CW-1:0]            cnt_q;
	logic [IW-1:0]            pos_q;
	logic                     valid_q;
	logic [DIGIT_CHAR_W-1:0]  char_q;
	logic [DIGIT_COUNT_W-1:0] count_q;
	logic                     last_q;
	logic [BCD_W-1:0]         cur_digit;

	assign pop = !active_q && !empty;
	assign cur_digit = digits_q[pos_q*BCD_W +: BCD_W];

	// Control: take an entry when free, then walk down to digit zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
			end else if (active_q && pos_q == '0) begin
				active_q <= 1'b0;
			end
		end
	end

	// Entry and output registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			digits_q <= digits;
			cnt_q <= count;
			pos_q <= IW'(count - 1'b1);
		end else if (active_q) begin
			pos_q <= pos_q - 1'b1;
		end
		if (active_q) begin
			char_q <= ASCII_ZERO + DIGIT_CHAR_W'(cur_digit);
			count_q <= DIGIT_COUNT_W'(cnt_q);
			last_q <= (pos_q == '0);
		end
	end

	assign valid = valid_q;
	assign digit_char = char_q;
	assign digit_count = count_q;
	assign last_digit = last_q;

endmodule
